// File: design/svgpd_pkg.sv
// svgpd_pkg: shared types, constants and helpers for the variable-gain PD steering block.
// No dependencies; imported by svgpd_ctrl, svgpd_dpath and steering_variable_gain_pd.
package svgpd_pkg;

   // Port widths
   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int Q_W        = 16;
   localparam int CMD_W      = 15;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_GAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ERROR_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_MAX    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_MIN    = 3'd4;

   // Default gains (Q4.12): 0.4, 2.0, 0.1; also forced on straight track
   localparam logic [Q_W-1:0] DEF_BASE_GAIN  = 16'd1638;
   localparam logic [Q_W-1:0] DEF_ERROR_GAIN = 16'd8192;
   localparam logic [Q_W-1:0] DEF_DERIV_GAIN = 16'd410;
   localparam logic signed [Q_W-1:0] DEF_OUT_MAX = 16'sd32767;
   localparam logic signed [Q_W-1:0] DEF_OUT_MIN = -16'sd32768;

   // Straight-track cap 2.1 and final limit 3.5
   localparam logic signed [Q_W-1:0] STRAIGHT_CAP = 16'sd8602;
   localparam logic signed [Q_W-1:0] FINAL_LIMIT  = 16'sd14336;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERR,
      ST_MULG,
      ST_GAIN,
      ST_MULP,
      ST_FIN
   } svgpd_state_type;

   // Controller to datapath: one strobe per step
   typedef struct packed {
      logic capture;
      logic err;
      logic mulg;
      logic gain;
      logic mulp;
      logic fin;
   } svgpd_cmd_type;

   // Round a Q10.24 product to Q4.12 (nearest, ties up) and saturate to 16 bits
   function automatic logic signed [Q_W-1:0] rnd_sat(input logic signed [33:0] x);
      logic signed [34:0] y;
      logic signed [22:0] q;
      logic signed [Q_W-1:0] r;
      y = {x[33], x} + 35'sd2048;
      q = y[34:12];
      if (q > 23'sd32767) begin
         r = 16'sd32767;
      end else if (q < -23'sd32768) begin
         r = -16'sd32768;
      end else begin
         r = q[15:0];
      end
      return r;
   endfunction

endpackage

// File: design/svgpd_ctrl.sv
// svgpd_ctrl: sequencer for one item, input and result handshakes.
// Depends on svgpd_pkg; drives svgpd_dpath by command strobes.
module svgpd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output svgpd_pkg::svgpd_cmd_type cmd
);
   import svgpd_pkg::*;

   svgpd_state_type state_ff, state_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_ERR;
         ST_ERR:  state_in = ST_MULG;
         ST_MULG: state_in = ST_GAIN;
         ST_GAIN: state_in = ST_MULP;
         ST_MULP: state_in = ST_FIN;
         ST_FIN:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs; no transfer is taken while reset is held
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = !reset;
            cmd.capture = req_tvalid && !reset;
         end
         ST_ERR:  cmd.err  = 1'b1;
         ST_MULG: cmd.mulg = 1'b1;
         ST_GAIN: cmd.gain = 1'b1;
         ST_MULP: cmd.mulp = 1'b1;
         ST_FIN:  cmd.fin  = out_free;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.fin) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_fin_free: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |-> (!rsp_valid_ff || rsp_tready))
      else $error("result written over an untaken transfer");
   a_cap_seq: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.err)
      else $error("captured item not processed");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.mulg || cmd.gain || cmd.mulp) |-> !req_tready)
      else $error("input taken mid-item");

endmodule

// File: design/svgpd_dpath.sv
// svgpd_dpath: error selection, variable-gain PD arithmetic, clamps, config registers.
// Depends on svgpd_pkg; sequenced by svgpd_ctrl command strobes.
module svgpd_dpath (
   input  logic                                     clock,
   input  logic                                     reset,
   input  svgpd_pkg::svgpd_cmd_type                 cmd,
   input  logic [svgpd_pkg::REQ_DATA_W-1:0]         req_tdata,
   input  logic [svgpd_pkg::REQ_USER_W-1:0]         req_tuser,
   input  logic                                     csr_we,
   input  logic [svgpd_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [svgpd_pkg::CSR_DATA_W-1:0]         csr_wdata,
   output logic signed [svgpd_pkg::CMD_W-1:0]       steer_command,
   output logic signed [svgpd_pkg::Q_W-1:0]         error_used
);
   import svgpd_pkg::*;

   // Config registers
   logic [Q_W-1:0]        base_gain_ff, error_gain_ff, deriv_gain_ff;
   logic signed [Q_W-1:0] out_max_ff, out_min_ff;
   logic signed [Q_W-1:0] prev_err_ff;

   // Captured item
   logic signed [Q_W-1:0] lk_ff, rk_ff;
   logic                  lv_ff, rv_ff, straight_ff;

   // Working registers
   logic signed [Q_W-1:0] e_ff, e_in;
   logic [Q_W-1:0]        mag_ff;
   logic signed [16:0]    diff_ff;
   logic [31:0]           prod_g_ff;
   logic signed [33:0]    prod_d_ff;
   logic [Q_W-1:0]        gain_ff, gain_in;
   logic signed [32:0]    prod_p_ff;
   logic signed [CMD_W-1:0] steer_ff;
   logic signed [Q_W-1:0] err_out_ff;

   logic signed [16:0] ksum;
   logic signed [16:0] e_neg;
   logic [32:0]        g_rnd;
   logic [21:0]        g_sum;
   logic signed [Q_W-1:0] p_term, d_term, r_val;
   logic signed [16:0] pd_sum;

   // Error selection
   always_comb begin
      ksum = 17'(lk_ff) + 17'(rk_ff) + 17'sd1;
      priority if (lv_ff && rv_ff) begin
         e_in = ksum[16:1];
      end else if (lv_ff) begin
         e_in = lk_ff;
      end else if (rv_ff) begin
         e_in = rk_ff;
      end else begin
         e_in = prev_err_ff;
      end
      e_neg = -17'(e_in);
   end

   // Variable gain: base + round(error_gain*|e|), saturated to 16 bits unsigned
   always_comb begin
      g_rnd = {1'b0, prod_g_ff} + 33'd2048;
      g_sum = {6'd0, base_gain_ff} + {1'b0, g_rnd[32:12]};
      gain_in = (g_sum > 22'd65535) ? 16'hFFFF : g_sum[15:0];
   end

   // Final combine and clamps
   always_comb begin
      p_term = rnd_sat(34'(prod_p_ff));
      d_term = rnd_sat(prod_d_ff);
      pd_sum = 17'(p_term) + 17'(d_term);
      if (pd_sum > 17'sd32767) begin
         r_val = 16'sd32767;
      end else if (pd_sum < -17'sd32768) begin
         r_val = -16'sd32768;
      end else begin
         r_val = pd_sum[15:0];
      end
      if (r_val >= out_max_ff) r_val = out_max_ff;
      if (r_val <= out_min_ff) r_val = out_min_ff;
      if (straight_ff && r_val > STRAIGHT_CAP) r_val = STRAIGHT_CAP;
      if (r_val > FINAL_LIMIT) r_val = FINAL_LIMIT;
      if (r_val < -FINAL_LIMIT) r_val = -FINAL_LIMIT;
   end

   // Config registers and previous error (straight track reloads the gains)
   always_ff @(posedge clock) begin
      if (reset) begin
         base_gain_ff  <= DEF_BASE_GAIN;
         error_gain_ff <= DEF_ERROR_GAIN;
         deriv_gain_ff <= DEF_DERIV_GAIN;
         out_max_ff    <= DEF_OUT_MAX;
         out_min_ff    <= DEF_OUT_MIN;
         prev_err_ff   <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_BASE_GAIN:  base_gain_ff  <= csr_wdata;
               CSR_ERROR_GAIN: error_gain_ff <= csr_wdata;
               CSR_DERIV_GAIN: deriv_gain_ff <= csr_wdata;
               CSR_OUT_MAX:    out_max_ff    <= csr_wdata;
               CSR_OUT_MIN:    out_min_ff    <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.err && straight_ff) begin
            base_gain_ff  <= DEF_BASE_GAIN;
            error_gain_ff <= DEF_ERROR_GAIN;
            deriv_gain_ff <= DEF_DERIV_GAIN;
         end
         if (cmd.fin) begin
            prev_err_ff <= e_ff;
         end
      end
   end

   // Payload pipeline
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         lk_ff       <= req_tdata[15:0];
         rk_ff       <= req_tdata[31:16];
         lv_ff       <= req_tuser[0];
         rv_ff       <= req_tuser[1];
         straight_ff <= req_tuser[2] | req_tuser[3];
      end
      if (cmd.err) begin
         e_ff    <= e_in;
         mag_ff  <= e_in[15] ? e_neg[15:0] : e_in;
         diff_ff <= 17'(e_in) - 17'(prev_err_ff);
      end
      if (cmd.mulg) begin
         prod_g_ff <= error_gain_ff * mag_ff;
         prod_d_ff <= $signed({1'b0, deriv_gain_ff}) * diff_ff;
      end
      if (cmd.gain) begin
         gain_ff <= gain_in;
      end
      if (cmd.mulp) begin
         prod_p_ff <= $signed({1'b0, gain_ff}) * e_ff;
      end
      if (cmd.fin) begin
         steer_ff   <= r_val[CMD_W-1:0];
         err_out_ff <= e_ff;
      end
   end

   assign steer_command = steer_ff;
   assign error_used    = err_out_ff;

   a_straight_gains: assert property (@(posedge clock) disable iff (reset)
      (cmd.err && straight_ff) |=> (base_gain_ff == DEF_BASE_GAIN &&
         error_gain_ff == DEF_ERROR_GAIN && deriv_gain_ff == DEF_DERIV_GAIN))
      else $error("straight-track gains not loaded");
   a_prev_upd: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |=> (prev_err_ff == err_out_ff))
      else $error("previous error out of step with result");

endmodule

// File: design/steering_variable_gain_pd.sv
// Variable-gain PD steering controller: outer curvature loop, Q4.12 fixed point.
// Each accepted input transfer runs a five-step sequencer (error select, gain and D
// multiplies, gain saturate, P multiply, combine/clamp); the result is registered in the
// last step, which waits while a result is untaken; no new input is taken before it ends.
// Reset (synchronous, active high): gains and clamps to defaults, previous error to 0,
// no result pending; no clearing pass.
module steering_variable_gain_pd (
   input  logic                                clock,
   input  logic                                reset,
   // Input stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [15:0] left_kappa, [31:16] right_kappa
   input  logic [svgpd_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] left_valid, [1] right_valid, [2] left_straight, [3] right_straight
   input  logic [svgpd_pkg::REQ_USER_W-1:0]    req_tuser,
   // Result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [14:0] steer_command, [30:15] error_used, [31] zero
   output logic [svgpd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // Register writes: 0 base_gain, 1 error_gain, 2 deriv_gain, 3 out_max, 4 out_min
   input  logic                                csr_we,
   input  logic [svgpd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [svgpd_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import svgpd_pkg::*;

   svgpd_cmd_type           cmd;
   logic signed [CMD_W-1:0] steer_command;
   logic signed [Q_W-1:0]   error_used;

   // Sequencer: takes one transfer at a time; the result register lets the
   // next transfer in while the previous result waits downstream.
   svgpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // Arithmetic and register file
   svgpd_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .steer_command (steer_command),
      .error_used    (error_used)
   );

   // Pack result fields, lowest first, padded to whole bytes
   assign rsp_tdata = {1'b0, error_used, steer_command};

endmodule
